### rtl/acm_pkg.sv
`default_nettype none
package acm_pkg;

  // Line store geometry: a ring of MAX_ORDER rows of MAX_WIDTH pixels.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_ORDER  = 5;
  localparam int MAX_ROWS   = 4096;
  localparam int COEF_NUM   = MAX_ORDER * MAX_ORDER;
  localparam int MEM_DEPTH  = MAX_ORDER * MAX_WIDTH;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int SW         = $clog2(MAX_ORDER);
  localparam int AW         = SW + XW;
  localparam int YW         = $clog2(MAX_ROWS);
  localparam int CIW        = $clog2(COEF_NUM);

  // Arithmetic widths: channel sum, folded numerator, scaled divisor.
  localparam int ACCW = 29;
  localparam int KW   = 50;
  localparam int DW   = 32;

  // Number of color channels, one cell each.
  localparam int NCH = 4;

  // Operation codes carried in tuser.
  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Register indexes.
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_ORDER_X  = 3'd1;
  localparam logic [2:0] REG_ORDER_Y  = 3'd2;
  localparam logic [2:0] REG_TARGET_X = 3'd3;
  localparam logic [2:0] REG_TARGET_Y = 3'd4;
  localparam logic [2:0] REG_DIVISOR  = 3'd5;
  localparam logic [2:0] REG_BIAS     = 3'd6;
  localparam logic [2:0] REG_PRESERVE = 3'd7;

  // One beat handed from cell to cell.
  typedef struct packed {
    logic               mac;
    logic               first;
    logic               fin;
    logic [31:0]        data;
    logic signed [15:0] coef;
  } link_t;

endpackage
`default_nettype wire

### rtl/acm_cell.sv
`default_nettype none
module acm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  acm_pkg::link_t               link_in,
  input  logic signed [acm_pkg::KW-1:0] kterm,
  input  logic [acm_pkg::DW-1:0]       den,
  input  logic                         neg,
  output acm_pkg::link_t               link_out,
  output logic [7:0]                   result,
  output logic                         done
);
  import acm_pkg::*;

  logic signed [ACCW-1:0] acc;
  logic signed [24:0]     prod;
  logic signed [KW-1:0]   acc_ext;
  logic signed [KW-1:0]   n_raw;
  logic signed [KW-1:0]   n_fold;
  logic signed [KW-1:0]   den_ext;
  logic signed [KW-1:0]   den_top;
  logic signed [KW-1:0]   trial;
  logic signed [KW-1:0]   rem;
  logic [7:0]             quo;
  logic [7:0]             quo_next;
  logic [2:0]             cnt;
  logic                   busy;
  logic                   pre;

  // Pass the beat on, with this cell's byte shifted out.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.mac   <= link_in.mac;
      link_out.first <= link_in.first;
      link_out.fin   <= link_in.fin;
      link_out.data  <= {8'd0, link_in.data[31:8]};
      link_out.coef  <= link_in.coef;
    end
  end

  // Multiply-accumulate on the low byte.
  assign prod = $signed({1'b0, link_in.data[7:0]}) * link_in.coef;

  always_ff @(posedge clk) begin
    if (link_in.mac) begin
      acc <= (link_in.first ? '0 : acc) + ACCW'(prod);
    end
  end

  // Numerator with bias and rounding folded in, sign of divisor applied.
  assign acc_ext  = KW'(acc);
  assign n_raw    = (acc_ext <<< 8) + kterm;
  assign n_fold   = neg ? -n_raw : n_raw;
  assign den_ext  = $signed({{(KW-DW){1'b0}}, den});
  assign den_top  = den_ext <<< 8;
  assign trial    = rem - (den_ext <<< cnt);

  always_comb begin
    quo_next = quo;
    if (!trial[KW-1]) begin
      quo_next[cnt] = 1'b1;
    end
  end

  // Restoring division, one quotient bit a cycle, after a range check.
  // The check pulls the numerator into range so that the quotient fits in
  // eight bits; every cell takes the same number of cycles.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pre  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (link_in.fin) begin
        busy <= 1'b1;
        pre  <= 1'b1;
      end else if (busy && pre) begin
        pre <= 1'b0;
      end else if (busy && cnt == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.fin) begin
      rem <= n_fold;
      cnt <= 3'd7;
      quo <= 8'd0;
    end else if (busy && pre) begin
      // A negative numerator gives zero, one of 256 divisors or more gives 255.
      if (rem[KW-1]) begin
        rem <= '0;
      end else if (rem >= den_top) begin
        rem <= den_top - KW'(1);
      end
    end else if (busy) begin
      if (!trial[KW-1]) begin
        rem <= trial;
      end
      quo <= quo_next;
      cnt <= cnt - 3'd1;
      if (cnt == 3'd0) begin
        result <= quo_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/argb_convolve_matrix_interior.sv
// ARGB convolution filter for the interior of an image.
// The slave stream carries coefficient loads (tuser bit 0 low) and pixels
// (tuser bit 0 high) in raster order; tuser bit 1 marks the first pixel of a
// frame. The master stream carries one filtered pixel with its destination
// column and row for every pixel whose window lies inside the image.
// The kernel comes over the slave stream; size, target, divisor, bias and
// alpha mode are set over the APB port, and the user is to write them only
// while the block is idle; the block does not enforce it. A coefficient
// load or a pixel that completes no window leaves the block idle; one that
// completes a window keeps it busy: the line memory has one read port, so
// the window is fetched one pixel a cycle into a chain of four channel
// cells, each then dividing one quotient bit a cycle. A new item is accepted
// while a finished result waits on the master side; if the receiver stalls,
// the next result waits in its cell until the output register frees.
// After reset all 5120 entries of the line memory are cleared, one a cycle;
// no item is accepted until then, configuration writes are.
`default_nettype none
module argb_convolve_matrix_interior (
  input  logic        clk,
  input  logic        rst,
  // tdata: coef_index[4:0], coef_value[20:5], pixel_in[52:21], zero pad
  input  logic [55:0] s_tdata,
  // tuser: operation[0], start_of_frame[1]
  input  logic [1:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: pixel_out[31:0], out_x[41:32], out_y[53:42], zero pad
  output logic [55:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Configuration registers.
  logic [10:0]        image_width;
  logic [2:0]         order_x;
  logic [2:0]         order_y;
  logic [2:0]         target_x;
  logic [2:0]         target_y;
  logic signed [23:0] divisor_value;
  logic signed [15:0] bias_value;
  logic               preserve_alpha;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // Stored state.
  logic [31:0]              line_mem [MEM_DEPTH];
  logic signed [15:0]       coef_mem [COEF_NUM];
  logic [XW-1:0]            column_count;
  logic [YW-1:0]            row_count;
  logic [SW-1:0]            ring_slot;
  logic                     clearing;
  logic [AW-1:0]            clr_cnt;

  logic [2:0]               state;
  logic [2:0]               state_next;

  // Derived arithmetic terms.
  logic signed [23:0]       d_eff;
  logic signed [39:0]       bd;
  logic signed [23:0]       dd;
  logic signed [KW-1:0]     kterm;
  logic [DW-1:0]            den;
  logic                     neg;
  logic [23:0]              d_abs;

  // Effective geometry.
  logic [10:0]              w_eff;
  logic [2:0]               ox_e;
  logic [2:0]               oy_e;
  logic [2:0]               tx_e;
  logic [2:0]               ty_e;

  // Input decode.
  logic                     acc_in;
  logic                     op;
  logic                     sof;
  logic [4:0]               cidx_in;
  logic signed [15:0]       cval_in;
  logic [31:0]              pix_in;

  // Position bookkeeping.
  logic                     wrap;
  logic [XW-1:0]            c_cur;
  logic [YW-1:0]            r_cur;
  logic [SW-1:0]            s_cur;
  logic [10:0]              nc;
  logic                     nwrap;
  logic                     emit;
  logic [10:0]              x0_w;
  logic [12:0]              ay_w;

  // Window scan registers.
  logic [SW-1:0]            cur_r;
  logic [XW-1:0]            x0_r;
  logic [2:0]               ox_r;
  logic [2:0]               oy_r;
  logic [2:0]               tx_r;
  logic [2:0]               ty_r;
  logic [XW-1:0]            ax_r;
  logic [YW-1:0]            ay_r;
  logic [2:0]               ky;
  logic [2:0]               kx;
  logic                     scan_last;
  logic [2:0]               back;
  logic [3:0]               slot_t;
  logic [3:0]               slot_rd;
  logic [AW-1:0]            raddr;
  logic [5:0]               cidx_full;
  logic [CIW-1:0]           cidx_rd;

  // Read stage.
  logic [31:0]              rdata;
  logic signed [15:0]       coef_r;
  logic                     rd_mac;
  logic                     rd_first;
  logic                     rd_fin;
  logic                     rd_tgt;
  logic [7:0]               alpha_r;

  // Cell chain.
  link_t                    link [NCH+1];
  logic [7:0]               res [NCH];
  logic [NCH-1:0]           cdone;
  logic                     out_load;

  // APB register writes and reads.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 11'd1024;
      order_x        <= 3'd3;
      order_y        <= 3'd3;
      target_x       <= 3'd1;
      target_y       <= 3'd1;
      divisor_value  <= 24'sd256;
      bias_value     <= 16'sd0;
      preserve_alpha <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:    image_width    <= pwdata[10:0];
        REG_ORDER_X:  order_x        <= pwdata[2:0];
        REG_ORDER_Y:  order_y        <= pwdata[2:0];
        REG_TARGET_X: target_x       <= pwdata[2:0];
        REG_TARGET_Y: target_y       <= pwdata[2:0];
        REG_DIVISOR:  divisor_value  <= pwdata[23:0];
        REG_BIAS:     bias_value     <= pwdata[15:0];
        REG_PRESERVE: preserve_alpha <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:    prdata = {21'd0, image_width};
      REG_ORDER_X:  prdata = {29'd0, order_x};
      REG_ORDER_Y:  prdata = {29'd0, order_y};
      REG_TARGET_X: prdata = {29'd0, target_x};
      REG_TARGET_Y: prdata = {29'd0, target_y};
      REG_DIVISOR:  prdata = {8'd0, divisor_value};
      REG_BIAS:     prdata = {16'd0, bias_value};
      REG_PRESERVE: prdata = {31'd0, preserve_alpha};
      default:      prdata = 32'd0;
    endcase
  end

  // Bias and divisor terms, kept current from the registers.
  assign d_eff = (divisor_value == 24'sd0) ? 24'sd256 : divisor_value;
  assign d_abs = neg ? 24'(-dd) : dd;

  always_ff @(posedge clk) begin
    bd    <= bias_value * d_eff;
    dd    <= d_eff;
    neg   <= dd[23];
    kterm <= (KW'(bd) <<< 8) - KW'(bd) + (KW'(dd) <<< 7);
  end
  assign den = {d_abs, 8'd0};

  // Geometry with out-of-range values pulled into range.
  always_comb begin
    w_eff = image_width;
    if (image_width == 11'd0) begin
      w_eff = 11'd1;
    end else if (image_width > 11'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end
    ox_e = order_x;
    if (order_x == 3'd0) begin
      ox_e = 3'd1;
    end else if (order_x > 3'(MAX_ORDER)) begin
      ox_e = 3'(MAX_ORDER);
    end
    oy_e = order_y;
    if (order_y == 3'd0) begin
      oy_e = 3'd1;
    end else if (order_y > 3'(MAX_ORDER)) begin
      oy_e = 3'(MAX_ORDER);
    end
    tx_e = (target_x < ox_e) ? target_x : ox_e - 3'd1;
    ty_e = (target_y < oy_e) ? target_y : oy_e - 3'd1;
  end

  // Input beat fields.
  assign acc_in   = s_tvalid && s_tready;
  assign op       = s_tuser[0];
  assign sof      = s_tuser[1];
  assign cidx_in  = s_tdata[4:0];
  assign cval_in  = s_tdata[20:5];
  assign pix_in   = s_tdata[52:21];
  assign s_tready = !clearing && (state == ST_IDLE);

  // Column, row and ring slot of the incoming pixel and after it.
  assign wrap  = !sof && ({1'b0, column_count} >= w_eff);
  assign c_cur = (sof || wrap) ? '0 : column_count;
  assign r_cur = sof ? '0 :
                 (wrap && row_count != YW'(MAX_ROWS - 1)) ? row_count + 1'b1 : row_count;
  assign s_cur = sof ? '0 :
                 wrap ? ((ring_slot == SW'(MAX_ORDER - 1)) ? '0 : ring_slot + 1'b1) :
                 ring_slot;
  assign nc    = {1'b0, c_cur} + 11'd1;
  assign nwrap = nc >= w_eff;
  assign emit  = (nc >= {8'd0, ox_e}) && (({1'b0, r_cur} + 13'd1) >= {10'd0, oy_e});
  assign x0_w  = nc - {8'd0, ox_e};
  assign ay_w  = {1'b0, r_cur} + 13'd1 - {10'd0, oy_e} + {10'd0, ty_e};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      ring_slot    <= '0;
    end else if (acc_in && op == OP_PIXEL) begin
      if (nwrap) begin
        column_count <= '0;
        row_count    <= (r_cur != YW'(MAX_ROWS - 1)) ? r_cur + 1'b1 : r_cur;
        ring_slot    <= (s_cur == SW'(MAX_ORDER - 1)) ? '0 : s_cur + 1'b1;
      end else begin
        column_count <= nc[XW-1:0];
        row_count    <= r_cur;
        ring_slot    <= s_cur;
      end
    end
  end

  // Coefficient store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_NUM; i++) begin
        coef_mem[i] <= '0;
      end
    end else if (acc_in && op == OP_COEF && cidx_in < 5'(COEF_NUM)) begin
      coef_mem[cidx_in[CIW-1:0]] <= cval_in;
    end
  end

  // Clearing pass over the line memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Window scan addressing.
  assign back      = oy_r - 3'd1 - ky;
  assign slot_t    = {1'b0, cur_r} + 4'(MAX_ORDER) - {1'b0, back};
  assign slot_rd   = (slot_t >= 4'(MAX_ORDER)) ? slot_t - 4'(MAX_ORDER) : slot_t;
  assign raddr     = {slot_rd[SW-1:0], x0_r + XW'(kx)};
  assign cidx_full = ky * ox_r + {3'd0, kx};
  assign cidx_rd   = cidx_full[CIW-1:0];
  assign scan_last = (kx == ox_r - 3'd1) && (ky == oy_r - 3'd1);

  // Line memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      line_mem[clr_cnt] <= 32'd0;
    end else if (acc_in && op == OP_PIXEL) begin
      line_mem[{s_cur, c_cur}] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= line_mem[raddr];
  end

  // Control sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc_in && op == OP_PIXEL && emit) state_next = ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_FIN;
      ST_FIN:  state_next = ST_WAIT;
      ST_WAIT: if (cdone[NCH-1]) state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc_in && op == OP_PIXEL && emit) begin
      cur_r <= s_cur;
      x0_r  <= x0_w[XW-1:0];
      ox_r  <= ox_e;
      oy_r  <= oy_e;
      tx_r  <= tx_e;
      ty_r  <= ty_e;
      ax_r  <= x0_w[XW-1:0] + XW'(tx_e);
      ay_r  <= ay_w[YW-1:0];
      ky    <= 3'd0;
      kx    <= 3'd0;
    end else if (state == ST_SCAN) begin
      if (kx == ox_r - 3'd1) begin
        kx <= 3'd0;
        ky <= ky + 3'd1;
      end else begin
        kx <= kx + 3'd1;
      end
    end
  end

  // Read stage: flags and coefficient travel with the memory data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_mac   <= 1'b0;
      rd_first <= 1'b0;
      rd_fin   <= 1'b0;
      rd_tgt   <= 1'b0;
    end else begin
      rd_mac   <= (state == ST_SCAN);
      rd_first <= (state == ST_SCAN) && (ky == 3'd0) && (kx == 3'd0);
      rd_fin   <= (state == ST_FIN);
      rd_tgt   <= (state == ST_SCAN) && (ky == ty_r) && (kx == tx_r);
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_mem[cidx_rd];
    if (rd_tgt) begin
      alpha_r <= rdata[31:24];
    end
  end

  assign link[0].mac   = rd_mac;
  assign link[0].first = rd_first;
  assign link[0].fin   = rd_fin;
  assign link[0].data  = rdata;
  assign link[0].coef  = coef_r;

  // One cell per channel, blue first.
  for (genvar g = 0; g < NCH; g++) begin : g_cell
    acm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (link[g]),
      .kterm    (kterm),
      .den      (den),
      .neg      (neg),
      .link_out (link[g+1]),
      .result   (res[g]),
      .done     (cdone[g])
    );
  end

  // Output register.
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'd0, ay_r, ax_r,
                  (preserve_alpha ? alpha_r : res[3]), res[2], res[1], res[0]};
    end
  end

  // Checks on the sequencer and the cell chain.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during memory clear");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cdone[NCH-1] |-> state == ST_WAIT)
    else $error("last cell finished outside wait state");

  a_done_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cdone))
    else $error("cells finished in the same cycle");

  a_fin_tail: assert property (@(posedge clk) disable iff (rst)
    link[NCH].fin |-> state == ST_WAIT)
    else $error("finish beat left the chain outside wait state");

endmodule
`default_nettype wire

### tb/argb_convolve_checker.sv
// Watches both streams and the APB port, predicts every filtered pixel and
// compares each output beat against the oldest prediction.
module argb_convolve_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import acm_pkg::*;

  typedef struct packed {
    logic [31:0] pix;
    logic [9:0]  x;
    logic [11:0] y;
  } filtered_t;

  filtered_t filtered_q[$];

  // Shadow of the block's line ring, kernel, position and registers.
  logic [31:0]        line_ring [MEM_DEPTH];
  logic signed [15:0] kernel [COEF_NUM];
  int unsigned        col_cnt, row_cnt, slot;
  logic [10:0]        width_r;
  logic [2:0]         ox_r, oy_r, tx_r, ty_r;
  logic signed [23:0] div_r;
  logic signed [15:0] bias_r;
  logic               pres_r;
  int                 errors;

  function automatic int unsigned clamp_order(logic [2:0] o);
    if (o < 1) return 1;
    if (o > MAX_ORDER) return MAX_ORDER;
    return o;
  endfunction

  // Divide, add scaled bias, round half up and clamp one channel.
  function automatic logic [7:0] round_channel(longint acc, longint d);
    longint n, den, q;
    n = 256 * acc + 255 * longint'(bias_r) * d + 128 * d;
    den = 256 * d;
    if (den < 0) begin
      n = -n;
      den = -den;
    end
    q = n / den;
    if ((n % den) != 0 && n < 0) q = q - 1;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic void next_row();
    col_cnt = 0;
    if (row_cnt < MAX_ROWS - 1) row_cnt++;
    slot = (slot + 1) % MAX_ORDER;
  endfunction

  // Update the shadow state for one input beat and queue any filtered pixel.
  task automatic predict_filtered(logic [55:0] data, logic [1:0] user);
    int unsigned w, ox, oy, tx, ty, col, row, cur, x0, aslot, s;
    longint      d;
    longint      acc [4];
    logic [31:0] p;
    logic [7:0]  res [4];
    filtered_t   e;
    if (user[0] == OP_COEF) begin
      if (data[4:0] < COEF_NUM) kernel[data[4:0]] = data[20:5];
      return;
    end
    w = width_r;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    ox = clamp_order(ox_r);
    oy = clamp_order(oy_r);
    tx = (tx_r < ox) ? tx_r : ox - 1;
    ty = (ty_r < oy) ? ty_r : oy - 1;
    if (user[1]) begin
      col_cnt = 0;
      row_cnt = 0;
      slot = 0;
    end else if (col_cnt >= w) begin
      next_row();
    end
    col = col_cnt;
    row = row_cnt;
    line_ring[slot * MAX_WIDTH + col] = data[52:21];
    col_cnt = col + 1;
    if (col_cnt >= w) next_row();
    if (col + 1 < ox || row + 1 < oy) return;

    cur = (col_cnt == 0) ? (slot + MAX_ORDER - 1) % MAX_ORDER : slot;
    x0 = col + 1 - ox;
    aslot = 0;
    for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (int unsigned ky = 0; ky < oy; ky++) begin
      s = (cur + MAX_ORDER - (oy - 1 - ky)) % MAX_ORDER;
      if (ky == ty) aslot = s;
      for (int unsigned kx = 0; kx < ox; kx++) begin
        p = line_ring[s * MAX_WIDTH + x0 + kx];
        for (int ch = 0; ch < 4; ch++)
          acc[ch] += longint'(p[8*ch +: 8]) * longint'(kernel[ky * ox + kx]);
      end
    end
    d = (div_r == 0) ? 256 : longint'(div_r);
    for (int ch = 0; ch < 3; ch++) res[ch] = round_channel(acc[ch], d);
    if (pres_r) res[3] = line_ring[aslot * MAX_WIDTH + x0 + tx][31:24];
    else res[3] = round_channel(acc[3], d);
    e.pix = {res[3], res[2], res[1], res[0]};
    e.x = 10'(x0 + tx);
    e.y = 12'(row + 1 - oy + ty);
    filtered_q.push_back(e);
  endtask

  always @(posedge clk) begin
    filtered_t e;
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) line_ring[i] = '0;
      for (int i = 0; i < COEF_NUM; i++) kernel[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      slot = 0;
      width_r = 11'd1024;
      ox_r = 3'd3;
      oy_r = 3'd3;
      tx_r = 3'd1;
      ty_r = 3'd1;
      div_r = 24'sd256;
      bias_r = '0;
      pres_r = 1'b0;
      filtered_q.delete();
      errors = 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WIDTH:    width_r = pwdata[10:0];
          REG_ORDER_X:  ox_r = pwdata[2:0];
          REG_ORDER_Y:  oy_r = pwdata[2:0];
          REG_TARGET_X: tx_r = pwdata[2:0];
          REG_TARGET_Y: ty_r = pwdata[2:0];
          REG_DIVISOR:  div_r = pwdata[23:0];
          REG_BIAS:     bias_r = pwdata[15:0];
          REG_PRESERVE: pres_r = pwdata[0];
          default: ;
        endcase
      end
      // Input beats are predicted before the output is checked, since a result
      // always belongs to an older beat.
      if (s_tvalid && s_tready) predict_filtered(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output beat %h", m_tdata);
          errors++;
        end else begin
          e = filtered_q.pop_front();
          if (m_tdata[31:0] !== e.pix) begin
            $error("pixel_out expected %h actual %h", e.pix, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[41:32] !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, m_tdata[41:32]);
            errors++;
          end
          if (m_tdata[53:42] !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, m_tdata[53:42]);
            errors++;
          end
        end
      end
    end
    pending <= filtered_q.size();
    fail_count <= errors;
  end

endmodule

### tb/tb_argb_convolve_matrix_interior.sv
// Stimulus and verdict for the ARGB convolution filter.
module tb_argb_convolve_matrix_interior;
  import acm_pkg::*;

  logic        clk;
  logic        rst;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int          idle_pct;
  int          stall_pct;
  logic        hold_off;
  int          items;

  argb_convolve_matrix_interior DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  argb_convolve_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: random stalls, or a long hold-off while hold_off is set.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("** argb_convolve_matrix_interior: FAILED **");
    $finish;
  end

  task automatic set_mode(int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 56; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 56; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  // Offer one beat and wait until it is taken.
  task automatic send(logic op, logic sof, logic [4:0] idx, logic [15:0] cv,
                      logic [31:0] px);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tdata  <= {3'b000, px, cv, idx};
    s_tuser  <= {sof, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items++;
  endtask

  // Wait until every predicted pixel has come out and the pipeline is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [10:0] w, logic [2:0] ox, logic [2:0] oy,
                           logic [2:0] tx, logic [2:0] ty, logic [23:0] dv,
                           logic [15:0] bs, logic pa);
    settle();
    apb_write(REG_WIDTH, {21'd0, w});
    apb_write(REG_ORDER_X, {29'd0, ox});
    apb_write(REG_ORDER_Y, {29'd0, oy});
    apb_write(REG_TARGET_X, {29'd0, tx});
    apb_write(REG_TARGET_Y, {29'd0, ty});
    apb_write(REG_DIVISOR, {{8{dv[23]}}, dv});
    apb_write(REG_BIAS, {{16{bs[15]}}, bs});
    apb_write(REG_PRESERVE, {31'd0, pa});
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  // Kernel load; start_of_frame is set at random, which the block ignores.
  task automatic load_kernel(int n);
    for (int i = 0; i < n; i++)
      send(OP_COEF, 1'($urandom_range(1)), 5'(i), rand_coef(), $urandom);
  endtask

  // One frame in raster order; extreme pixels alternate 0 and all ones.
  task automatic frame(int w, int rows, bit fresh, bit extreme);
    logic [31:0] px;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        if (extreme) px = ((r + c) % 2) ? 32'hffff_ffff : 32'h0;
        else if ($urandom_range(0, 9) == 0) px = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        else px = $urandom;
        send(OP_PIXEL, fresh && r == 0 && c == 0, 5'($urandom), 16'($urandom), px);
      end
    end
  endtask

  initial begin
    int          phase;
    int          ox, oy, w, eff;
    logic [2:0]  oxr, oyr, txr, tyr;
    logic [23:0] dv;
    logic [15:0] bs;
    logic [10:0] wr;
    bit          fresh;

    rst = 1'b1;
    s_tdata = '0;
    s_tuser = '0;
    s_tvalid = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off = 1'b0;
    items = 0;
    set_mode(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: coefficient extremes, an out-of-range index, start of frame
    // on a load, then a small frame of extreme pixels.
    configure(11'd4, 3'd3, 3'd3, 3'd1, 3'd1, 24'd256, 16'd0, 1'b0);
    send(OP_COEF, 1'b0, 5'd0, 16'h8000, 32'h0);
    send(OP_COEF, 1'b0, 5'd24, 16'h7fff, 32'h0);
    send(OP_COEF, 1'b0, 5'd31, 16'h1234, 32'hffff_ffff);
    send(OP_COEF, 1'b1, 5'd4, 16'd256, 32'h0);
    frame(4, 3, 1, 1);

    // Width above the maximum, divisor zero, bias maximum, alpha preserved.
    configure(11'd2047, 3'd1, 3'd1, 3'd0, 3'd0, 24'd0, 16'h7fff, 1'b1);
    load_kernel(1);
    frame(20, 1, 1, 0);
    // Width and orders zero, targets out of range, divisor and bias minimum.
    configure(11'd0, 3'd0, 3'd0, 3'd7, 3'd7, 24'h800000, 16'h8000, 1'b0);
    load_kernel(1);
    frame(1, 6, 1, 0);
    // Largest kernel with the largest divisor.
    configure(11'd8, 3'd5, 3'd5, 3'd4, 3'd4, 24'h7fffff, 16'd0, 1'b0);
    load_kernel(25);
    frame(8, 6, 1, 0);
    // Orders above the maximum with a negative divisor.
    configure(11'd6, 3'd7, 3'd7, 3'd7, 3'd7, 24'hffff00, 16'd100, 1'b1);
    load_kernel(25);
    frame(6, 5, 1, 0);
    // Width lowered in the middle of a row: the next pixel starts a new row.
    configure(11'd8, 3'd2, 3'd2, 3'd0, 3'd1, 24'd256, 16'd0, 1'b0);
    load_kernel(4);
    frame(5, 1, 1, 0);
    configure(11'd3, 3'd2, 3'd2, 3'd0, 3'd1, 24'd256, 16'd0, 1'b0);
    frame(3, 3, 0, 0);
    // A tall column of one-pixel rows.
    configure(11'd1, 3'd1, 3'd2, 3'd0, 3'd1, 24'd256, 16'd0, 1'b0);
    load_kernel(2);
    frame(1, 40, 1, 0);

    // Random phases: a fresh configuration, a kernel, then a frame.
    phase = 0;
    while (items < 650) begin
      case ($urandom_range(0, 9))
        0: oxr = $urandom_range(1) ? 3'd0 : 3'($urandom_range(6, 7));
        default: oxr = 3'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 9))
        0: oyr = $urandom_range(1) ? 3'd0 : 3'($urandom_range(6, 7));
        default: oyr = 3'($urandom_range(1, 5));
      endcase
      ox = (oxr < 1) ? 1 : (oxr > MAX_ORDER) ? MAX_ORDER : oxr;
      oy = (oyr < 1) ? 1 : (oyr > MAX_ORDER) ? MAX_ORDER : oyr;
      txr = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, ox - 1));
      tyr = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, oy - 1));
      case ($urandom_range(0, 19))
        0: wr = 11'd0;
        1: wr = 11'($urandom_range(1025, 2047));
        default: wr = 11'($urandom_range(ox, 12));
      endcase
      // The hold-off phase needs short rows so that results come out.
      if (phase == 3) wr = 11'($urandom_range(ox, 12));
      case ($urandom_range(0, 5))
        0: dv = 24'd0;
        1: dv = 24'd256;
        2: dv = 24'($urandom);
        3: dv = 24'($urandom_range(1, 8000));
        4: dv = 24'(-$urandom_range(1, 8000));
        default: dv = $urandom_range(1) ? 24'h800000 : 24'h7fffff;
      endcase
      bs = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512) - 256);
      configure(wr, oxr, oyr, txr, tyr, dv, bs, 1'($urandom_range(1)));
      set_mode(phase % 4);
      load_kernel(($urandom_range(0, 3) == 0) ? COEF_NUM : ox * oy);
      if ($urandom_range(0, 2) == 0)
        send(OP_COEF, 1'b0, 5'($urandom_range(25, 31)), rand_coef(), $urandom);
      w = wr;
      eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      fresh = ($urandom_range(0, 5) != 0);
      if (phase == 3) begin
        // Long receiver hold-off while pixels keep coming.
        fork
          begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
          frame((eff > 16) ? 20 : eff, (eff > 16) ? 1 : 7, 1, 0);
        join
      end else if (eff > 16) begin
        frame(20, 1, fresh, 0);
      end else begin
        frame(eff, $urandom_range(1, 7), fresh, 0);
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("** argb_convolve_matrix_interior: PASSED **");
    end else begin
      $display("** argb_convolve_matrix_interior: FAILED **");
    end
    $finish;
  end

endmodule
